// File: rtl/pidf_pkg.sv
// ----------------------------------------------------------------------------
// pidf_pkg
// Shared types and constants of the filtered-derivative PID controller.
// ----------------------------------------------------------------------------
package pidf_pkg;

  // multiplier operand width of the serial multiplier (gains, filter weights)
  localparam int MulBits = 17;
  localparam int MulCntBits = 5;

  // filter weight of one in Q1.16
  localparam logic [MulBits-1:0] K_ONE = 17'h10000;

  // rounding offsets
  localparam int RND_DERIV = 32768;
  localparam int RND_DRIVE = 128;

  // register reset values
  localparam logic [15:0] RST_GAIN_P = 16'd1792;
  localparam logic [15:0] RST_GAIN_I = 16'd0;
  localparam logic [15:0] RST_GAIN_D = 16'd0;
  localparam logic [16:0] RST_FILT_K = 17'd45875;
  localparam int RST_UPPER = 20480;
  localparam int RST_LOWER = -20480;

  // register indexes
  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_FILT_K = 3'd3;
  localparam logic [2:0] REG_UPPER  = 3'd4;
  localparam logic [2:0] REG_LOWER  = 3'd5;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DERIV,
    ST_DRIVE
  } pidf_state_t;

  // product being formed
  typedef enum logic [2:0] {
    PH_KDIFF,
    PH_KPREV,
    PH_PROP,
    PH_INTEG,
    PH_DERIV
  } pidf_phase_t;

  // command to the serial multiplier
  typedef struct packed {
    logic start;
    logic clear;
  } mul_cmd_t;

endpackage

// File: rtl/pidf_if.sv
// ----------------------------------------------------------------------------
// pidf_in_if / pidf_out_if
// Valid/ready channels for samples and drive values.
// ----------------------------------------------------------------------------
interface pidf_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] setpoint;
  logic [W-1:0] feedback;
  modport source (output valid, setpoint, feedback, input ready);
  modport sink   (input valid, setpoint, feedback, output ready);
endinterface

interface pidf_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

// File: rtl/pidf_serial_mul.sv
// ----------------------------------------------------------------------------
// pidf_serial_mul
// Bit-serial shift-and-add multiply-accumulate, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module pidf_serial_mul
  import pidf_pkg::*;
#(
  parameter int AW = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mul_cmd_t            cmd,
  input  logic [AW-1:0]       mcand,
  input  logic [MulBits-1:0]  mplier,
  input  logic [AW-1:0]       acc_init,
  output logic                busy,
  output logic [AW-1:0]       acc
);

  logic [AW-1:0]         acc_r;
  logic [AW-1:0]         m_r;
  logic [MulBits-1:0]    b_r;
  logic [MulCntBits-1:0] cnt_r;

  // bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= MulCntBits'(MulBits);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      m_r <= mcand;
      b_r <= mplier;
      if (cmd.clear) begin
        acc_r <= acc_init;
      end
    end else if (cnt_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + m_r;
      end
      m_r <= {m_r[AW-2:0], 1'b0};
      b_r <= {1'b0, b_r[MulBits-1:1]};
    end
  end

  assign busy = (cnt_r != '0);
  assign acc  = acc_r;

endmodule

// File: rtl/positional_pid_filtered_derivative.sv
// ----------------------------------------------------------------------------
// positional_pid_filtered_derivative
// Positional PID with conditional-integration anti-windup and filtered
// derivative, built around one bit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
// One sample pair is taken while the block is idle and one drive value comes
// out once five products have been formed one after another on a single
// shift-and-add multiplier that retires one bit of a 17-bit gain or filter
// weight per cycle, with a step each for sample entry, derivative rounding
// and drive clamping. The next sample is taken as soon as the drive is in
// the output register, even if it has not been collected yet. Configuration
// writes are expected only while idle.
module positional_pid_filtered_derivative
  import pidf_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pidf_in_if.sink                     in_ch,
  pidf_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [((SAMPLE_WIDTH > 17) ? SAMPLE_WIDTH : 17)-1:0] cfg_wdata
);

  localparam int S  = SAMPLE_WIDTH;
  localparam int IW = INTEGRAL_WIDTH;
  localparam int CW = (S > 17) ? S : 17;
  localparam int DW = S + 8;
  // accumulator holds the exact sum of all three drive terms and the
  // unshifted derivative sum; AW leaves room for the widest term and the
  // carries of the sum, so no per-term clipping is needed
  localparam int AW = ((IW + 19) > (S + 28)) ? (IW + 19) : (S + 28);

  // configuration registers
  logic [15:0]        gain_p_r, gain_i_r, gain_d_r;
  logic [16:0]        filt_k_r;
  logic signed [S-1:0] upper_r, lower_r;

  // controller state
  logic signed [IW-1:0] integ_r;
  logic signed [S:0]    prev_err_r;
  logic signed [DW-1:0] prev_deriv_r;
  logic signed [S-1:0]  prev_drive_r;
  logic signed [S:0]    err_r;

  // sequencer
  pidf_state_t state_r, state_nxt;
  pidf_phase_t phase_r, phase_nxt;

  // output register
  logic         out_valid_r;
  logic [S-1:0] out_drive_r;

  // multiplier connections
  mul_cmd_t      mul_cmd;
  logic [AW-1:0] mul_mcand;
  logic [MulBits-1:0] mul_mplier;
  logic [AW-1:0] mul_init;
  logic          mul_busy;
  logic [AW-1:0] mul_acc;

  logic in_acc;
  logic out_free;

  // datapath signals
  logic signed [S:0]    err_new;
  logic signed [S+1:0]  diff;
  logic                 integ_add;
  logic signed [IW:0]   integ_sum;
  logic signed [IW-1:0] integ_new;
  logic [MulBits-1:0]   k_eff;
  logic signed [AW-1:0] acc_s, deriv_sh, drive_sh;
  logic signed [DW-1:0] deriv_new;
  logic signed [S-1:0]  drive_new;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= RST_GAIN_P;
      gain_i_r <= RST_GAIN_I;
      gain_d_r <= RST_GAIN_D;
      filt_k_r <= RST_FILT_K;
      upper_r  <= S'(RST_UPPER);
      lower_r  <= S'(RST_LOWER);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P: gain_p_r <= cfg_wdata[15:0];
        REG_GAIN_I: gain_i_r <= cfg_wdata[15:0];
        REG_GAIN_D: gain_d_r <= cfg_wdata[15:0];
        REG_FILT_K: filt_k_r <= cfg_wdata[16:0];
        REG_UPPER:  upper_r  <= cfg_wdata[S-1:0];
        REG_LOWER:  lower_r  <= cfg_wdata[S-1:0];
        default: ;
      endcase
    end
  end

  // error, anti-windup and integral
  always_comb begin
    err_new = $signed({in_ch.setpoint[S-1], in_ch.setpoint})
            - $signed({in_ch.feedback[S-1], in_ch.feedback});
    diff    = $signed({err_new[S], err_new}) - $signed({prev_err_r[S], prev_err_r});
    if (prev_drive_r >= upper_r) begin
      integ_add = err_new[S];
    end else if (prev_drive_r <= lower_r) begin
      integ_add = !err_new[S] && (err_new != '0);
    end else begin
      integ_add = 1'b1;
    end
    integ_sum = $signed({integ_r[IW-1], integ_r}) + (IW+1)'(err_new);
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_new = {integ_sum[IW], {(IW-1){~integ_sum[IW]}}};
    end else begin
      integ_new = integ_sum[IW-1:0];
    end
    k_eff = (filt_k_r > K_ONE) ? K_ONE : filt_k_r;
  end

  // derivative rounding and drive clamp from the accumulator
  always_comb begin
    acc_s    = $signed(mul_acc);
    deriv_sh = acc_s >>> 16;
    drive_sh = acc_s >>> 8;
    if ((&deriv_sh[AW-1:DW-1]) || !(|deriv_sh[AW-1:DW-1])) begin
      deriv_new = deriv_sh[DW-1:0];
    end else begin
      deriv_new = {deriv_sh[AW-1], {(DW-1){~deriv_sh[AW-1]}}};
    end
    if (drive_sh > AW'(upper_r)) begin
      drive_new = upper_r;
    end else if (drive_sh < AW'(lower_r)) begin
      drive_new = lower_r;
    end else begin
      drive_new = drive_sh[S-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_MUL;
          phase_nxt = PH_KDIFF;
        end
      end
      ST_MUL: begin
        if (!mul_busy) begin
          case (phase_r)
            PH_KDIFF: phase_nxt = PH_KPREV;
            PH_KPREV: state_nxt = ST_DERIV;
            PH_PROP:  phase_nxt = PH_INTEG;
            PH_INTEG: phase_nxt = PH_DERIV;
            PH_DERIV: state_nxt = ST_DRIVE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DERIV: begin
        state_nxt = ST_MUL;
        phase_nxt = PH_PROP;
      end
      ST_DRIVE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier commands and operands
  always_comb begin
    mul_cmd    = '0;
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_init   = '0;
    case (state_r)
      ST_IDLE: begin
        mul_cmd.start = in_acc;
        mul_cmd.clear = 1'b1;
        mul_init      = AW'(RND_DERIV);
        mul_mcand     = AW'(diff);
        mul_mplier    = k_eff;
      end
      ST_MUL: begin
        if (!mul_busy) begin
          case (phase_r)
            PH_KDIFF: begin
              mul_cmd.start = 1'b1;
              mul_mcand     = AW'(prev_deriv_r);
              mul_mplier    = K_ONE - k_eff;
            end
            PH_PROP: begin
              mul_cmd.start = 1'b1;
              mul_mcand     = AW'(integ_r);
              mul_mplier    = {1'b0, gain_i_r};
            end
            PH_INTEG: begin
              mul_cmd.start = 1'b1;
              mul_mcand     = AW'(prev_deriv_r);
              mul_mplier    = {1'b0, gain_d_r};
            end
            default: ;
          endcase
        end
      end
      ST_DERIV: begin
        mul_cmd.start = 1'b1;
        mul_cmd.clear = 1'b1;
        mul_init      = AW'(RND_DRIVE);
        mul_mcand     = AW'(err_r);
        mul_mplier    = {1'b0, gain_p_r};
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_KDIFF;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // controller state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      prev_err_r   <= '0;
      prev_deriv_r <= '0;
      prev_drive_r <= '0;
    end else begin
      if (in_acc) begin
        if (integ_add) begin
          integ_r <= integ_new;
        end
        prev_err_r <= err_new;
      end
      if (state_r == ST_DERIV) begin
        prev_deriv_r <= deriv_new;
      end
      if (state_r == ST_DRIVE && out_free) begin
        prev_drive_r <= drive_new;
      end
    end
  end

  // error of the current transaction for the proportional term
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r <= err_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DRIVE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DRIVE && out_free) begin
      out_drive_r <= drive_new;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = out_drive_r;

  // shared multiply-accumulate unit
  pidf_serial_mul #(
    .AW (AW)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mul_cmd),
    .mcand    (mul_mcand),
    .mplier   (mul_mplier),
    .acc_init (mul_init),
    .busy     (mul_busy),
    .acc      (mul_acc)
  );

`ifndef SYNTHESIS
  // multiplier is quiet whenever a new transaction may enter
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mul_busy)
    else $error("multiplier busy while idle");

  // an accepted transaction starts a product at once
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (mul_busy && !in_ch.ready))
    else $error("no product started after accept");

  // a drive is only written once the last product has finished
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRIVE) |-> !mul_busy)
    else $error("drive clamped before products done");
`endif

endmodule
